// File: sv/lpis_pkg.sv
// Shared constants, types and controller codes for the largest-prime stream block.
package lpis_pkg;

    // Width of one signed input value and of the result value.
    localparam int VALUE_WIDTH = 16;
    // Stream data width: the value padded to whole bytes.
    localparam int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
    // Bit index into a value for the serial remainder unit.
    localparam int BIT_IDX_WIDTH = $clog2(VALUE_WIDTH);

    // The first trial divisor and its square.
    localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH:0]   FIRST_SQUARE  = (VALUE_WIDTH + 1)'(4);
    // Result value when a sequence holds no prime: -1.
    localparam logic [VALUE_WIDTH-1:0] NO_PRIME_VALUE = '1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOD,
        ST_TEST,
        ST_FINISH
    } lpis_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take a new request into the datapath
        logic mod_start;  // clear the remainder and start a new division
        logic mod_step;   // one bit of the restoring remainder
        logic next_div;   // advance to the next trial divisor
        logic mark_prime; // the value under test is prime
        logic commit;     // fold the verdict into the running maximum
    } lpis_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_le1;    // value is one, zero or negative
        logic sq_gt_n;  // square of the divisor exceeds the value
        logic mod_last; // the remainder unit is on its final bit
        logic rem_zero; // the divisor divides the value
        logic last;     // the request closes a sequence
        logic out_free; // the output register can take a result
    } lpis_status_t;

endpackage

// File: sv/lpis_ctrl.sv
// Controller state machine that sequences trial division for each request.
module lpis_ctrl
    import lpis_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  lpis_status_t status,
    output lpis_cmd_t    cmd
);

    lpis_state_t state_reg;
    lpis_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (status.n_le1 || status.sq_gt_n) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (status.mod_last) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (status.rem_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (!status.last || status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHECK: begin
                priority if (status.n_le1) begin
                    cmd.mark_prime = 1'b0;
                end else if (status.sq_gt_n) begin
                    cmd.mark_prime = 1'b1;
                end else begin
                    cmd.mod_start = 1'b1;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
            end
            ST_TEST: begin
                cmd.next_div = !status.rem_zero;
            end
            ST_FINISH: begin
                cmd.commit = !status.last || status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/lpis_dp.sv
// Datapath: value and divisor registers, serial remainder unit, running maximum, output register.
module lpis_dp
    import lpis_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lpis_cmd_t              cmd,
    output lpis_status_t           status,
    input  logic [VALUE_WIDTH-1:0] in_value,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] out_value,
    output logic                   out_found
);

    logic [VALUE_WIDTH-1:0]   n_reg;
    logic                     last_reg;
    logic [VALUE_WIDTH-1:0]   d_reg,  d_next;
    logic [VALUE_WIDTH:0]     sq_reg, sq_next;
    logic [VALUE_WIDTH-1:0]   rem_reg, rem_next;
    logic [BIT_IDX_WIDTH-1:0] cnt_reg, cnt_next;
    logic                     verdict_reg, verdict_next;
    logic [VALUE_WIDTH-1:0]   best_reg, best_next;
    logic                     have_reg, have_next;
    logic [VALUE_WIDTH-1:0]   out_value_reg, out_value_next;
    logic                     out_found_reg, out_found_next;
    logic                     out_valid_reg, out_valid_next;

    logic [VALUE_WIDTH:0]     shifted;
    logic                     is_better;
    logic [VALUE_WIDTH-1:0]   best_upd;
    logic                     have_upd;
    logic                     emit;

    // Status toward the controller.
    always_comb begin
        status.n_le1    = n_reg[VALUE_WIDTH-1] || (n_reg[VALUE_WIDTH-1:1] == '0);
        status.sq_gt_n  = sq_reg > {1'b0, n_reg};
        status.mod_last = (cnt_reg == '0);
        status.rem_zero = (rem_reg == '0);
        status.last     = last_reg;
        status.out_free = !out_valid_reg || out_ready;
    end

    // Restoring remainder, one dividend bit per step, most significant first.
    always_comb begin
        shifted  = {rem_reg, n_reg[cnt_reg]};
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.mod_start) begin
            rem_next = '0;
            cnt_next = BIT_IDX_WIDTH'(VALUE_WIDTH - 1);
        end else if (cmd.mod_step) begin
            if (shifted >= {1'b0, d_reg}) begin
                rem_next = VALUE_WIDTH'(shifted - {1'b0, d_reg});
            end else begin
                rem_next = shifted[VALUE_WIDTH-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Trial divisor and its square; (d+1)^2 = d^2 + 2d + 1.
    always_comb begin
        d_next  = d_reg;
        sq_next = sq_reg;
        if (cmd.load) begin
            d_next  = FIRST_DIVISOR;
            sq_next = FIRST_SQUARE;
        end else if (cmd.next_div) begin
            d_next  = d_reg + 1'b1;
            sq_next = sq_reg + {d_reg, 1'b1};
        end
    end

    // Verdict on the value under test.
    always_comb begin
        verdict_next = verdict_reg;
        if (cmd.load) begin
            verdict_next = 1'b0;
        end else if (cmd.mark_prime) begin
            verdict_next = 1'b1;
        end
    end

    // Running maximum and the result for a closing request.
    always_comb begin
        is_better      = verdict_reg && (!have_reg || (n_reg > best_reg));
        best_upd       = is_better ? n_reg : best_reg;
        have_upd       = have_reg || verdict_reg;
        emit           = cmd.commit && last_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        out_value_next = out_value_reg;
        out_found_next = out_found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (emit) begin
            best_next      = '0;
            have_next      = 1'b0;
            out_value_next = have_upd ? best_upd : NO_PRIME_VALUE;
            out_found_next = have_upd;
            out_valid_next = 1'b1;
        end else if (cmd.commit) begin
            best_next = best_upd;
            have_next = have_upd;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg      <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
            verdict_reg   <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            have_reg      <= have_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
            verdict_reg   <= verdict_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg    <= in_value;
            last_reg <= in_last;
        end
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        rem_reg       <= rem_next;
        out_value_reg <= out_value_next;
        out_found_reg <= out_found_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_found = out_found_reg;

`ifndef SYNTH
    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && last_reg) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    // Without a prime the result value is -1.
    a_none_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> (out_value_reg == NO_PRIME_VALUE))
        else $error("primeless result is not -1");

    // A reported prime is positive.
    a_prime_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_found_reg) |-> !out_value_reg[VALUE_WIDTH-1])
        else $error("reported prime is negative");

    // A division starts at the top bit of the value.
    a_mod_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_start |=> (cnt_reg == BIT_IDX_WIDTH'(VALUE_WIDTH - 1)) && (rem_reg == '0))
        else $error("remainder unit did not restart");
`endif

endmodule

// File: sv/largest_prime_in_stream_top.sv
// Top level of the largest-prime stream block: controller and datapath.
//
// Each request carries one signed value and a last flag; the block tests the value for
// primality by trial division and keeps the largest prime of the current sequence. On
// a request with last set it delivers one result, the largest prime with found set in
// tuser, or -1 with found clear, and starts a new sequence. Trial divisors run from 2
// up to the square root of the value, and stop early when a divisor is found; each
// trial runs on the bit-serial remainder unit, which retires one dividend bit per cycle.
// A waiting result sits in an output register, so new requests are taken while it is
// pending.
module largest_prime_in_stream_top
    import lpis_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_WIDTH-1:0] s_axis_tdata,  // [VALUE_WIDTH-1:0] value, rest zero
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_WIDTH-1:0] m_axis_tdata,  // [VALUE_WIDTH-1:0] largest_prime, rest zero
    output logic                   m_axis_tuser   // [0] found
);

    lpis_cmd_t              cmd;
    lpis_status_t           status;
    logic [VALUE_WIDTH-1:0] out_value;

    // Sequencer.
    lpis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    lpis_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_value  (s_axis_tdata[VALUE_WIDTH-1:0]),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (out_value),
        .out_found (m_axis_tuser)
    );

    // Pad the result value to the stream width.
    assign m_axis_tdata = TDATA_WIDTH'(out_value);

endmodule
